[sv/sfmt_pkg.sv]
package sfmt_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 16;
  localparam int unsigned DEF_FLAG_KINDS    = 4;
  localparam int unsigned DEF_COUNT_BITS    = 16;

  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned FIDX_W    = 2;
  localparam int unsigned UCNT_W    = 16;
  // Wide enough for any slot number up to 255.
  localparam int unsigned IDX_MAX_W = 8;

  typedef enum logic [MODE_W-1:0] {
    OP_ADD_PERM = 3'd0,
    OP_ADD_TEMP = 3'd1,
    OP_DELETE   = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_CHECK    = 3'd4
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] station_address;
    logic [FIDX_W-1:0] flag_index;
    logic [UCNT_W-1:0] use_count;
  } in_item_t;

  typedef struct packed {
    logic hit;
    logic entry_removed;
    logic status;
  } out_item_t;

  // Walk summary handed from cell to cell along the chain.
  typedef struct packed {
    logic                 found;
    logic                 free_seen;
    logic [IDX_MAX_W-1:0] free_idx;
    logic                 hit;
    logic                 removed;
  } walk_acc_t;

endpackage

[sv/sfmt_cell.sv]
module sfmt_cell #(
  parameter int unsigned FLAG_KINDS = sfmt_pkg::DEF_FLAG_KINDS,
  parameter int unsigned COUNT_BITS = sfmt_pkg::DEF_COUNT_BITS,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tok_in,
  input  sfmt_pkg::walk_acc_t          acc_in,
  input  sfmt_pkg::op_t                cmd_op,
  input  logic [sfmt_pkg::ADDR_W-1:0]  cmd_addr,
  input  logic [FLAG_KINDS-1:0]        cmd_bit,
  input  logic [COUNT_BITS-1:0]        cmd_cnt,
  input  logic                         alloc_en,
  output logic                         tok_out,
  output sfmt_pkg::walk_acc_t          acc_out
);
  import sfmt_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [FLAG_KINDS-1:0] flags_r, flags_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic                  perm_r, perm_nxt;
  logic                  tok_r;
  walk_acc_t             acc_r, acc_nxt;

  logic                  match;
  logic                  cmd_perm;
  logic [FLAG_KINDS-1:0] flags_clr;

  assign match     = valid_r && (addr_r == cmd_addr);
  assign cmd_perm  = (cmd_op == OP_ADD_PERM);
  assign flags_clr = flags_r & ~cmd_bit;

  always_comb begin
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    flags_nxt = flags_r;
    rem_nxt   = rem_r;
    perm_nxt  = perm_r;
    acc_nxt   = acc_in;
    if (alloc_en) begin
      valid_nxt = 1'b1;
      addr_nxt  = cmd_addr;
      flags_nxt = cmd_bit;
      perm_nxt  = cmd_perm;
      rem_nxt   = cmd_perm ? '0 : cmd_cnt;
    end else if (tok_in) begin
      case (cmd_op)
        OP_ADD_PERM, OP_ADD_TEMP: begin
          if (match) begin
            flags_nxt     = flags_r | cmd_bit;
            perm_nxt      = cmd_perm;
            rem_nxt       = cmd_perm ? '0 : cmd_cnt;
            acc_nxt.found = 1'b1;
          end else if (!valid_r && !acc_in.free_seen) begin
            acc_nxt.free_seen = 1'b1;
            acc_nxt.free_idx  = IDX_MAX_W'(CELL_IDX);
          end
        end
        OP_DELETE: begin
          if (match) begin
            flags_nxt = flags_clr;
            if (flags_clr == '0) begin
              valid_nxt       = 1'b0;
              acc_nxt.removed = 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          if (valid_r) begin
            flags_nxt = flags_clr;
            if (flags_clr == '0) begin
              valid_nxt       = 1'b0;
              acc_nxt.removed = 1'b1;
            end
          end
        end
        OP_CHECK: begin
          if (match && ((flags_r & cmd_bit) != '0)) begin
            acc_nxt.hit = 1'b1;
            if (!perm_r && (rem_r != '0)) begin
              rem_nxt = rem_r - COUNT_BITS'(1);
              if (rem_r == COUNT_BITS'(1)) begin
                valid_nxt       = 1'b0;
                acc_nxt.removed = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    flags_r <= flags_nxt;
    rem_r   <= rem_nxt;
    perm_r  <= perm_nxt;
    acc_r   <= acc_nxt;
  end

  assign tok_out = tok_r;
  assign acc_out = acc_r;

endmodule

[sv/station_flag_match_table.sv]
// Station flag match table.
// Holds up to TABLE_ENTRIES unique 48-bit station addresses, each with
// FLAG_KINDS flag bits and a permanent mark or a remaining-use count.
// Input channel: in_data (mode, station_address, flag_index, use_count)
// is taken at a rising edge where start is high and busy is low.
// Result channel: out_data (hit, entry_removed, status) is shown for one
// cycle with out_valid high; the receiver cannot stall it, and it must
// take the beat in that cycle.
// Each entry lives in one cell of a chain. A command is held at the top
// while a token walks the chain one cell per cycle, carrying the running
// summary (match found, lowest free slot, hit, removal). A new address is
// written into the free slot in the cycle the token leaves the last cell.
// The result is registered as the token leaves the last cell, and busy stays
// high from accept until then, so a new item is taken only once the walk of
// the last one is over.
// Items that change nothing (unused mode, flag index out of range, add
// temporary with zero count) answer in the cycle after accept, without busy.
// Reset empties the table and drops any item in flight.
module station_flag_match_table #(
  parameter int unsigned TABLE_ENTRIES = sfmt_pkg::DEF_TABLE_ENTRIES,
  parameter int unsigned FLAG_KINDS    = sfmt_pkg::DEF_FLAG_KINDS,
  parameter int unsigned COUNT_BITS    = sfmt_pkg::DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sfmt_pkg::in_item_t  in_data,
  output logic                out_valid,
  output sfmt_pkg::out_item_t out_data
);
  import sfmt_pkg::*;

  localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

  state_t                state_r, state_nxt;
  logic                  go_r, go_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  op_t                   op_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [FLAG_KINDS-1:0] bit_r;
  logic [COUNT_BITS-1:0] cnt_r;

  logic                  accept;
  logic                  skip;
  logic                  finish;
  logic                  is_add;
  logic                  alloc;
  logic [COUNT_BITS-1:0] cnt_sat;
  logic [FLAG_KINDS-1:0] bit_in;

  logic [TABLE_ENTRIES:0]   tok;
  walk_acc_t                acc [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] alloc_vec;

  assign accept = start && !busy;

  // Items that leave the table untouched and answer all zero.
  assign skip = (in_data.mode > MODE_W'(OP_CHECK)) ||
                (32'(in_data.flag_index) >= FLAG_KINDS) ||
                ((in_data.mode == MODE_W'(OP_ADD_TEMP)) && (in_data.use_count == '0));

  // Saturate the use count to the count width.
  assign cnt_sat = (32'(in_data.use_count) > CNT_MAX) ? COUNT_BITS'(CNT_MAX)
                                                      : COUNT_BITS'(in_data.use_count);
  assign bit_in  = FLAG_KINDS'(1) << in_data.flag_index;

  // Token leaving the last cell closes the walk.
  assign finish = tok[TABLE_ENTRIES];
  assign is_add = (op_r == OP_ADD_PERM) || (op_r == OP_ADD_TEMP);
  assign alloc  = finish && is_add && !acc[TABLE_ENTRIES].found &&
                  acc[TABLE_ENTRIES].free_seen;

  assign tok[0] = go_r;
  assign acc[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    assign alloc_vec[i] = alloc && (acc[TABLE_ENTRIES].free_idx == IDX_MAX_W'(i));

    sfmt_cell #(
      .FLAG_KINDS (FLAG_KINDS),
      .COUNT_BITS (COUNT_BITS),
      .CELL_IDX   (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (tok[i]),
      .acc_in   (acc[i]),
      .cmd_op   (op_r),
      .cmd_addr (addr_r),
      .cmd_bit  (bit_r),
      .cmd_cnt  (cnt_r),
      .alloc_en (alloc_vec[i]),
      .tok_out  (tok[i+1]),
      .acc_out  (acc[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    go_nxt        = 1'b0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (skip) begin
            // Answer at once with an all-zero beat.
            out_valid_nxt = 1'b1;
          end else begin
            go_nxt    = 1'b1;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (finish) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.hit           = acc[TABLE_ENTRIES].hit;
          out_data_nxt.entry_removed = acc[TABLE_ENTRIES].removed;
          out_data_nxt.status        = is_add && !acc[TABLE_ENTRIES].found &&
                                       !acc[TABLE_ENTRIES].free_seen;
          state_nxt                  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the command for the whole walk.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept && !skip) begin
      op_r   <= op_t'(in_data.mode);
      addr_r <= in_data.station_address;
      bit_r  <= bit_in;
      cnt_r  <= cnt_sat;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/sfmt_checker.sv]
module sfmt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input sfmt_pkg::in_item_t  in_data,
  input logic                out_valid,
  input sfmt_pkg::out_item_t out_data
);
  import sfmt_pkg::*;

  // Reset leaves the block idle with no beat pending.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // An unused mode answers on the next cycle with an all-zero beat.
  a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.mode > MODE_W'(OP_CHECK))) |=>
      (out_valid && (out_data == '0)))
    else $error("unused mode did not answer with zeros");

  // The end of a walk always delivers its beat.
  a_walk_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("walk ended without a result beat");

  // A full-table add neither hits nor removes.
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> (!out_data.hit && !out_data.entry_removed))
    else $error("full status mixed with hit or removal");

endmodule

bind station_flag_match_table sfmt_checker u_sfmt_checker (.*);

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfmt_pkg::*;

  localparam int SLOTS      = DEF_TABLE_ENTRIES;
  localparam int POOL_SIZE  = 24;
  localparam int CMD_TARGET = 1920;
  // Quiet cycles allowed before the run is declared hung. A correct run never
  // sees more than one walk plus the longest sender gap.
  localparam int HANG_LIMIT = 4000;
  // Cycles to keep watching after the last expected result has arrived.
  localparam int TAIL_CYCLES = 2 * (DEF_TABLE_ENTRIES + 2) + 4;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  station_flag_match_table DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Commands waiting to be sent and outcomes waiting to be seen.
  in_item_t  cmd_q[$];
  out_item_t outcome_q[$];

  int err_count   = 0;
  int sent_count  = 0;
  int total_cmds  = 0;
  int idle_cycles = 0;

  // Shadow copy of the station table.
  logic        tbl_valid[SLOTS];
  logic [47:0] tbl_addr[SLOTS];
  logic [3:0]  tbl_flags[SLOTS];
  logic [15:0] tbl_left[SLOTS];
  logic        tbl_perm[SLOTS];

  logic [47:0] station_pool[POOL_SIZE];

  task automatic flag_error(string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void table_drop(int s);
    tbl_valid[s] = 1'b0;
    tbl_flags[s] = '0;
    tbl_left[s]  = '0;
    tbl_perm[s]  = 1'b0;
  endfunction

  function automatic int table_find(logic [47:0] a);
    for (int s = 0; s < SLOTS; s++) begin
      if (tbl_valid[s] && tbl_addr[s] == a) return s;
    end
    return -1;
  endfunction

  // Apply one command to the shadow table and return the outcome it gives.
  function automatic out_item_t table_apply(in_item_t it);
    out_item_t   res;
    int          slot;
    logic [3:0]  flag_bit;
    logic        perm;
    res = '0;
    if (it.mode > OP_CHECK) return res;
    flag_bit = 4'b0001 << it.flag_index;
    slot = table_find(it.station_address);
    case (it.mode)
      OP_ADD_PERM, OP_ADD_TEMP: begin
        perm = (it.mode == OP_ADD_PERM);
        // Temporary add with nothing to count is dropped.
        if (!perm && it.use_count == '0) return res;
        if (slot < 0) begin
          for (int s = 0; s < SLOTS && slot < 0; s++) begin
            if (!tbl_valid[s]) slot = s;
          end
          if (slot < 0) begin
            res.status = 1'b1;
            return res;
          end
          tbl_valid[slot] = 1'b1;
          tbl_addr[slot]  = it.station_address;
          tbl_flags[slot] = '0;
        end
        tbl_flags[slot] |= flag_bit;
        tbl_perm[slot]  = perm;
        tbl_left[slot]  = perm ? 16'd0 : it.use_count;
      end
      OP_DELETE: begin
        if (slot >= 0) begin
          tbl_flags[slot] &= ~flag_bit;
          if (tbl_flags[slot] == '0) begin
            table_drop(slot);
            res.entry_removed = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (tbl_valid[s]) begin
            tbl_flags[s] &= ~flag_bit;
            if (tbl_flags[s] == '0) begin
              table_drop(s);
              res.entry_removed = 1'b1;
            end
          end
        end
      end
      default: begin
        if (slot >= 0 && (tbl_flags[slot] & flag_bit) != '0) begin
          res.hit = 1'b1;
          // Count a temporary entry down; drop it once the uses run out.
          if (!tbl_perm[slot] && tbl_left[slot] != '0) begin
            tbl_left[slot] -= 16'd1;
            if (tbl_left[slot] == '0) begin
              table_drop(slot);
              res.entry_removed = 1'b1;
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic queue_cmd(logic [2:0] m, logic [47:0] a, logic [1:0] f, logic [15:0] c);
    in_item_t it;
    it.mode            = m;
    it.station_address = a;
    it.flag_index      = f;
    it.use_count       = c;
    cmd_q.push_back(it);
  endtask

  function automatic logic [47:0] pick_station();
    if ($urandom_range(0, 99) < 88) return station_pool[$urandom_range(0, POOL_SIZE - 1)];
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom());
      default: return 16'($urandom_range(1, 5));
    endcase
  endfunction

  // Driver: present one command per beat, in bursts with random gaps.
  int       burst_left = 1;
  int       gap_left   = 0;
  in_item_t cur_cmd;
  logic     took_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took_beat = start && !busy;
      if (took_beat) begin
        outcome_q.push_back(table_apply(cur_cmd));
        sent_count++;
      end
      // Hold the beat until the block takes it.
      if (!start || took_beat) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cur_cmd = cmd_q.pop_front();
          in_data <= cur_cmd;
          start   <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest outcome still owed.
  out_item_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (outcome_q.size() == 0) begin
        flag_error($sformatf("result with nothing expected (%b)", out_data));
      end else begin
        want = outcome_q.pop_front();
        if (out_data.hit !== want.hit)
          flag_error($sformatf("hit %b, want %b", out_data.hit, want.hit));
        if (out_data.entry_removed !== want.entry_removed)
          flag_error($sformatf("entry_removed %b, want %b",
                               out_data.entry_removed, want.entry_removed));
        if (out_data.status !== want.status)
          flag_error($sformatf("status %b, want %b", out_data.status, want.status));
      end
    end
  end

  // Watchdog: count cycles with neither a command taken nor a result shown.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  logic [47:0] sta_a, sta_b;
  logic [1:0]  fl;
  int          uses;
  int          roll;
  int          base;

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    for (int s = 0; s < SLOTS; s++) begin
      tbl_addr[s] = '0;
      table_drop(s);
    end
    station_pool[0] = '0;
    station_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) station_pool[k] = 48'({$urandom(), $urandom()});

    // Directed part: extremes, every mode, and the corner cases.
    sta_a = station_pool[2];
    sta_b = station_pool[3];
    queue_cmd(OP_ADD_PERM, 48'h0, 2'd0, 16'd0);
    queue_cmd(OP_ADD_TEMP, '1, 2'd3, 16'hFFFF);
    queue_cmd(OP_CHECK, 48'h0, 2'd0, 16'hFFFF);
    queue_cmd(OP_CHECK, '1, 2'd3, 16'd0);
    queue_cmd(OP_CHECK, '1, 2'd2, 16'd0);      // flag not set
    queue_cmd(OP_CHECK, sta_a, 2'd1, 16'd0);   // absent address
    queue_cmd(OP_ADD_TEMP, sta_a, 2'd1, 16'd0); // zero count, ignored
    queue_cmd(3'd5, '1, 2'd3, 16'hFFFF);       // unused modes
    queue_cmd(3'd6, 48'h0, 2'd0, 16'd1);
    queue_cmd(3'd7, sta_a, 2'd2, 16'h8000);
    queue_cmd(OP_ADD_PERM, '1, 2'd1, 16'd7);   // existing entry becomes permanent
    queue_cmd(OP_CHECK, '1, 2'd3, 16'd0);
    queue_cmd(OP_DELETE, '1, 2'd3, 16'd0);
    queue_cmd(OP_DELETE, sta_b, 2'd0, 16'd0);  // absent address
    queue_cmd(OP_DELETE, '1, 2'd1, 16'd0);     // last flag, entry goes
    queue_cmd(OP_ADD_TEMP, sta_a, 2'd2, 16'd1);
    queue_cmd(OP_CHECK, sta_a, 2'd2, 16'd0);   // last use, entry goes
    queue_cmd(OP_ADD_TEMP, sta_b, 2'd1, 16'd2);
    queue_cmd(OP_ADD_PERM, sta_a, 2'd1, 16'd0);
    queue_cmd(OP_CLEAR, 48'h0, 2'd1, 16'd0);
    queue_cmd(OP_CHECK, sta_b, 2'd1, 16'd0);
    queue_cmd(OP_CLEAR, '1, 2'd0, 16'd0);
    queue_cmd(OP_CLEAR, sta_a, 2'd0, 16'hFFFF); // nothing left to clear

    // Random part: mostly add/check sequences, some table fills, some noise.
    while (cmd_q.size() < CMD_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // Try to add the whole pool so the table runs out of slots.
        base = $urandom_range(0, POOL_SIZE - 1);
        for (int k = 0; k < POOL_SIZE; k++)
          queue_cmd($urandom_range(0, 1) ? OP_ADD_TEMP : OP_ADD_PERM,
                    station_pool[(base + k) % POOL_SIZE], 2'($urandom()),
                    16'($urandom_range(1, 6)));
      end else if (roll < 45) begin
        // Add temporary, then check it until its uses run out.
        sta_a = pick_station();
        fl    = 2'($urandom());
        uses  = $urandom_range(1, 4);
        queue_cmd(OP_ADD_TEMP, sta_a, fl, 16'(uses));
        for (int k = 0; k <= uses; k++)
          queue_cmd(OP_CHECK, sta_a, ($urandom_range(0, 4) == 0) ? 2'($urandom()) : fl,
                    16'($urandom()));
      end else if (roll < 55) begin
        // Permanent entry: check it a few times, then delete the flag.
        sta_a = pick_station();
        fl    = 2'($urandom());
        queue_cmd(OP_ADD_PERM, sta_a, fl, 16'($urandom()));
        queue_cmd(OP_CHECK, sta_a, fl, 16'($urandom()));
        queue_cmd(OP_CHECK, sta_a, 2'($urandom()), 16'($urandom()));
        queue_cmd(OP_DELETE, sta_a, fl, 16'($urandom()));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 4)       queue_cmd(3'($urandom_range(5, 7)), 48'({$urandom(), $urandom()}),
                                      2'($urandom()), 16'($urandom()));
        else if (roll < 8)  queue_cmd(OP_CLEAR, 48'({$urandom(), $urandom()}), 2'($urandom()),
                                      16'($urandom()));
        else if (roll < 25) queue_cmd(OP_DELETE, pick_station(), 2'($urandom()), pick_count());
        else if (roll < 55) queue_cmd(OP_CHECK, pick_station(), 2'($urandom()), pick_count());
        else if (roll < 75) queue_cmd(OP_ADD_TEMP, pick_station(), 2'($urandom()), pick_count());
        else                queue_cmd(OP_ADD_PERM, pick_station(), 2'($urandom()), pick_count());
      end
    end
    total_cmds = cmd_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every command is taken and every outcome seen, or a hang.
    while ((sent_count < total_cmds || outcome_q.size() != 0) && idle_cycles < HANG_LIMIT)
      @(posedge clk);
    if (idle_cycles < HANG_LIMIT) repeat (TAIL_CYCLES) @(posedge clk);

    if (idle_cycles >= HANG_LIMIT || err_count != 0 || outcome_q.size() != 0) begin
      $display("tb: failure");
    end else begin
      $display("tb: success");
    end
    $finish;
  end

endmodule
